### rtl/core/sphere_cube_classifier_unit_defines.svh
// Assertion macros shared by the sphere-cube classifier RTL.
`ifndef SPHERE_CUBE_CLASSIFIER_UNIT_DEFINES_SVH
`define SPHERE_CUBE_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SCC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/scc_pkg.sv
// Types and constants of the sphere-cube classifier.
package scc_pkg;

  typedef enum logic [1:0] {
    REL_DISJOINT   = 2'd0,
    REL_INTERSECTS = 2'd1,
    REL_CONTAINS   = 2'd2
  } relation_t;

  typedef logic [1:0] reg_index_t;

  localparam reg_index_t REG_CENTER_X = 2'd0;
  localparam reg_index_t REG_CENTER_Y = 2'd1;
  localparam reg_index_t REG_CENTER_Z = 2'd2;
  localparam reg_index_t REG_RADIUS   = 2'd3;

  localparam int CORNER_COUNT = 8;
  localparam int AXIS_COUNT = 3;
  localparam logic [CORNER_COUNT-1:0] ALL_CORNERS = 8'hff;

  localparam int OUT_FIELD_BITS = 10;
  localparam int OUT_TDATA_BITS = 16;

endpackage

### rtl/core/scc_axis.sv
// One axis of the classifier: corner offsets, saturated magnitude, squares.
module scc_axis #(
  parameter int COORD_BITS = 24
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [COORD_BITS-1:0] cube_min,
  input  logic [COORD_BITS-2:0]       cube_side,
  input  logic signed [COORD_BITS-1:0] center,
  output logic [2*COORD_BITS-1:0]     sq_lo,
  output logic [2*COORD_BITS-1:0]     sq_hi,
  output logic                        lo_above,
  output logic                        hi_below
);

  localparam int DW = COORD_BITS + 2;
  localparam logic [DW-1:0] LIM = DW'(1) << (COORD_BITS - 1);

  logic signed [DW-1:0]   d_lo;
  logic signed [DW-1:0]   d_hi;
  logic [COORD_BITS-1:0]  mag_lo;
  logic [COORD_BITS-1:0]  mag_hi;
  logic                   lo_above_s1;
  logic                   hi_below_s1;
  logic [2*COORD_BITS-1:0] sq_lo_next;
  logic [2*COORD_BITS-1:0] sq_hi_next;

  function automatic logic [COORD_BITS-1:0] sat_mag(input logic signed [DW-1:0] d);
    logic [DW-1:0] a;
    a = d[DW-1] ? DW'(-d) : DW'(d);
    if (a > LIM) begin
      a = LIM;
    end
    return a[COORD_BITS-1:0];
  endfunction

  assign d_lo = DW'(cube_min) - DW'(center);
  assign d_hi = d_lo + $signed(DW'(cube_side));

  assign sq_lo_next = mag_lo * mag_lo;
  assign sq_hi_next = mag_hi * mag_hi;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_lo      <= sat_mag(d_lo);
      mag_hi      <= sat_mag(d_hi);
      lo_above_s1 <= !d_lo[DW-1] && (d_lo != '0);
      hi_below_s1 <= d_hi[DW-1];
      sq_lo       <= sq_lo_next;
      sq_hi       <= sq_hi_next;
      lo_above    <= lo_above_s1;
      hi_below    <= hi_below_s1;
    end
  end

endmodule

### rtl/core/sphere_cube_classifier_unit.sv
// Top level of the sphere-cube classifier.
// Classifies an axis-aligned cube against a configured sphere.
// Input stream s_*: one cube query per transaction, fields packed in s_tdata.
// Output stream m_*: one result per query, in order, packed in m_tdata.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 center_x,
// 1 center_y, 2 center_z, 3 sphere_radius); write only while no query is in
// flight.
// Pipeline: four register stages (offsets, squares, sums, compare); m_tdata
// is driven from the compare stage registers.
// Throughput: one query per cycle unless stalled (fully pipelined squarers).
// Reset (rst, synchronous): zeroes the config registers and empties the pipe.
// Stall: while m_tvalid is high and m_tready low the whole pipe holds and
// s_tready drops; nothing is lost or repeated.
`include "sphere_cube_classifier_unit_defines.svh"

module sphere_cube_classifier_unit #(
  parameter int COORD_BITS = 24,
  localparam int IN_BITS = 4 * COORD_BITS - 1,
  localparam int IN_W = ((IN_BITS + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // cube_min_x, cube_min_y, cube_min_z, cube_side
  input  logic [IN_W-1:0]                    s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // relation, corner_mask
  output logic [scc_pkg::OUT_TDATA_BITS-1:0] m_tdata,
  input  logic                               cfg_we,
  input  scc_pkg::reg_index_t                cfg_index,
  input  logic [COORD_BITS-1:0]              cfg_data
);

  localparam int SW = 2 * COORD_BITS + 2;
  localparam int NC = scc_pkg::CORNER_COUNT;
  localparam int NA = scc_pkg::AXIS_COUNT;

  logic signed [COORD_BITS-1:0] center [NA];
  logic [COORD_BITS-2:0]        sphere_radius;
  logic [2*COORD_BITS-3:0]      radius_sq;

  logic signed [COORD_BITS-1:0] cube_min [NA];
  logic [COORD_BITS-2:0]        cube_side;

  logic                         advance;
  logic                         s1_valid;
  logic                         s2_valid;
  logic                         s3_valid;

  logic [2*COORD_BITS-1:0]      sq_lo [NA];
  logic [2*COORD_BITS-1:0]      sq_hi [NA];
  logic                         lo_above [NA];
  logic                         hi_below [NA];

  logic [SW-1:0]                corner_sum_next [NC];
  logic [SW-1:0]                gap_sum_next;
  logic [SW-1:0]                corner_sum [NC];
  logic [SW-1:0]                gap_sum;

  logic [NC-1:0]                mask_next;
  scc_pkg::relation_t           relation_next;
  logic [NC-1:0]                out_mask;
  scc_pkg::relation_t           out_relation;

  assign cube_min[0] = s_tdata[COORD_BITS-1:0];
  assign cube_min[1] = s_tdata[2*COORD_BITS-1:COORD_BITS];
  assign cube_min[2] = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
  assign cube_side   = s_tdata[4*COORD_BITS-2:3*COORD_BITS];

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      center[0]     <= '0;
      center[1]     <= '0;
      center[2]     <= '0;
      sphere_radius <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        scc_pkg::REG_CENTER_X: center[0] <= cfg_data;
        scc_pkg::REG_CENTER_Y: center[1] <= cfg_data;
        scc_pkg::REG_CENTER_Z: center[2] <= cfg_data;
        scc_pkg::REG_RADIUS:   sphere_radius <= cfg_data[COORD_BITS-2:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    radius_sq <= sphere_radius * sphere_radius;
  end

  for (genvar a = 0; a < NA; a++) begin : g_axis
    scc_axis #(
      .COORD_BITS(COORD_BITS)
    ) u_axis (
      .clk      (clk),
      .en       (advance),
      .cube_min (cube_min[a]),
      .cube_side(cube_side),
      .center   (center[a]),
      .sq_lo    (sq_lo[a]),
      .sq_hi    (sq_hi[a]),
      .lo_above (lo_above[a]),
      .hi_below (hi_below[a])
    );
  end

  always_comb begin
    logic [2*COORD_BITS-1:0] gap_sq [NA];
    logic [2*COORD_BITS-1:0] pick [NA];
    for (int a = 0; a < NA; a++) begin
      if (lo_above[a]) begin
        gap_sq[a] = sq_lo[a];
      end else if (hi_below[a]) begin
        gap_sq[a] = sq_hi[a];
      end else begin
        gap_sq[a] = '0;
      end
    end
    gap_sum_next = SW'(gap_sq[0]) + SW'(gap_sq[1]) + SW'(gap_sq[2]);
    for (int i = 0; i < NC; i++) begin
      for (int a = 0; a < NA; a++) begin
        pick[a] = i[NA-1-a] ? sq_hi[a] : sq_lo[a];
      end
      corner_sum_next[i] = SW'(pick[0]) + SW'(pick[1]) + SW'(pick[2]);
    end
  end

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      mask_next[i] = corner_sum[i] < SW'(radius_sq);
    end
    if (mask_next == scc_pkg::ALL_CORNERS) begin
      relation_next = scc_pkg::REL_CONTAINS;
    end else if (mask_next != '0 || gap_sum <= SW'(radius_sq)) begin
      relation_next = scc_pkg::REL_INTERSECTS;
    end else begin
      relation_next = scc_pkg::REL_DISJOINT;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      corner_sum   <= corner_sum_next;
      gap_sum      <= gap_sum_next;
      out_mask     <= mask_next;
      out_relation <= relation_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      s1_valid <= s_tvalid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      m_tvalid <= s3_valid;
    end
  end

  assign m_tdata = {(scc_pkg::OUT_TDATA_BITS - scc_pkg::OUT_FIELD_BITS)'(0),
                    out_mask, out_relation};

  `SCC_ASSERT_SAME(a_contains_iff_all, clk, rst, m_tvalid,
    (out_relation == scc_pkg::REL_CONTAINS) == (out_mask == scc_pkg::ALL_CORNERS),
    "contains reported without all corners inside, or the reverse")
  `SCC_ASSERT_SAME(a_partial_intersects, clk, rst,
    m_tvalid && out_mask != '0 && out_mask != scc_pkg::ALL_CORNERS,
    out_relation == scc_pkg::REL_INTERSECTS,
    "partial corner mask without intersects")
  `SCC_ASSERT_NEXT(a_accept_enters, clk, rst, s_tvalid && s_tready, s1_valid,
    "accepted transaction did not enter the pipe")
  `SCC_ASSERT_NEXT(a_stall_freezes, clk, rst, !s_tready,
    $stable(s1_valid) && $stable(s2_valid) && $stable(s3_valid),
    "pipe moved during an output stall")

endmodule
